// ----- rtl/json_string_unescape_utf8_core_macros.svh -----
// Assertion helpers shared by the decoder core modules.
`ifndef JSON_STRING_UNESCAPE_UTF8_CORE_MACROS_SVH
`define JSON_STRING_UNESCAPE_UTF8_CORE_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define JSU_ASSERT_NOW(lbl, ck, rs, ante, cons, msg) \
  lbl: assert property (@(posedge ck) disable iff (rs) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is high.
`define JSU_ASSERT_NEXT(lbl, ck, rs, ante, cons, msg) \
  lbl: assert property (@(posedge ck) disable iff (rs) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/jsu_pkg.sv -----
`default_nettype none

package jsu_pkg;

  // Most results a single input byte can produce (three replayed hex
  // characters plus the current byte or an end marker).
  localparam int MaxRes    = 4;
  localparam int ResQDepth = 8;
  localparam int ResQAw    = $clog2(ResQDepth);
  localparam int ResQCw    = $clog2(ResQDepth + 1);
  localparam int CapW      = 11;
  localparam int CntW      = 11;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       byte_valid;
    logic       string_done;
    logic [9:0] written_count;
  } jsu_res_t;

endpackage

`default_nettype wire

// ----- rtl/jsu_decode.sv -----
`default_nettype none

`include "json_string_unescape_utf8_core_macros.svh"

module jsu_decode
  import jsu_pkg::*;
(
  input  wire logic                     clk,
  input  wire logic                     rst,
  input  wire logic                     item_valid,
  input  wire logic [7:0]               in_byte,
  input  wire logic                     in_start,
  input  wire logic [CapW-1:0]          cap,
  output logic [2:0]                    res_cnt,
  output jsu_res_t [MaxRes-1:0]         res
);

  localparam logic [1:0] PhNormal = 2'd0;
  localparam logic [1:0] PhEscape = 2'd1;
  localparam logic [1:0] PhHex    = 2'd2;

  localparam logic [7:0] ChNul    = 8'h00;
  localparam logic [7:0] ChQuote  = 8'h22;
  localparam logic [7:0] ChBslash = 8'h5C;
  localparam logic [7:0] ChLowB   = 8'h62;
  localparam logic [7:0] ChLowF   = 8'h66;
  localparam logic [7:0] ChLowN   = 8'h6E;
  localparam logic [7:0] ChLowR   = 8'h72;
  localparam logic [7:0] ChLowT   = 8'h74;
  localparam logic [7:0] ChLowU   = 8'h75;
  localparam logic [7:0] ChLf     = 8'h0A;
  localparam logic [7:0] ChTab    = 8'h09;

  localparam logic [15:0] CpSurLo  = 16'hD800;
  localparam logic [15:0] CpSurHi  = 16'hDFFF;
  localparam logic [15:0] CpTwoMin = 16'h0080;
  localparam logic [15:0] CpThrMin = 16'h0800;
  localparam logic [7:0]  LeadTwo  = 8'hC0;
  localparam logic [7:0]  LeadThr  = 8'hE0;
  localparam logic [7:0]  ContMark = 8'h80;

  // Returns {valid, value} for an ASCII hex digit.
  function automatic logic [4:0] hex_digit(input logic [7:0] c);
    logic [4:0] r;
    r = 5'd0;
    if (c >= 8'h30 && c <= 8'h39) begin
      r = {1'b1, 4'(c - 8'h30)};
    end else if (c >= 8'h61 && c <= 8'h66) begin
      r = {1'b1, 4'(c - 8'h57)};
    end else if (c >= 8'h41 && c <= 8'h46) begin
      r = {1'b1, 4'(c - 8'h37)};
    end
    return r;
  endfunction

  logic [1:0]      phase;
  logic [1:0]      hex_n;
  logic [7:0]      hex_ch [3];
  logic [CntW-1:0] bw;
  logic            ended;

  logic [1:0]      e_phase;
  logic [1:0]      e_n;
  logic [7:0]      e_ch [3];
  logic [CntW-1:0] e_bw;
  logic            e_ended;

  logic [1:0]      phase_next;
  logic [1:0]      hex_n_next;
  logic [7:0]      hex_ch_next [3];
  logic [CntW-1:0] bw_next;
  logic            ended_next;

  logic            full;
  logic [11:0]     room;
  logic [2:0]      r_sat;
  logic [4:0]      hd;
  logic [4:0]      d0;
  logic [4:0]      d1;
  logic [4:0]      d2;
  logic [15:0]     cp;
  logic [7:0]      w [MaxRes];
  logic [2:0]      nw;
  logic            fin;
  logic            fin_out;
  logic [2:0]      e_cnt;

  always_comb begin
    // A start flag clears the decoding state before this byte is taken.
    e_phase = in_start ? PhNormal : phase;
    e_n     = in_start ? 2'd0 : hex_n;
    for (int i = 0; i < 3; i++) begin
      e_ch[i] = in_start ? 8'h00 : hex_ch[i];
    end
    e_bw    = in_start ? '0 : bw;
    e_ended = in_start ? 1'b0 : ended;

    full  = ({1'b0, e_bw} + 12'd1) >= {1'b0, cap};
    room  = {1'b0, cap} - {1'b0, e_bw} - 12'd1;
    r_sat = (room >= 12'd7) ? 3'd7 : room[2:0];

    hd = hex_digit(in_byte);
    d0 = hex_digit(e_ch[0]);
    d1 = hex_digit(e_ch[1]);
    d2 = hex_digit(e_ch[2]);
    cp = {d0[3:0], d1[3:0], d2[3:0], hd[3:0]};

    phase_next = e_phase;
    hex_n_next = e_n;
    for (int i = 0; i < 3; i++) begin
      hex_ch_next[i] = e_ch[i];
    end
    for (int i = 0; i < MaxRes; i++) begin
      w[i] = 8'h00;
    end
    nw  = 3'd0;
    fin = 1'b0;

    if (!e_ended && !full) begin
      case (e_phase)
        PhEscape: begin
          phase_next = PhNormal;
          if (in_byte == ChNul) begin
            fin = 1'b1;
          end else if (in_byte == ChLowN) begin
            w[0] = ChLf;
            nw   = 3'd1;
          end else if (in_byte == ChLowT) begin
            w[0] = ChTab;
            nw   = 3'd1;
          end else if (in_byte == ChLowR || in_byte == ChLowB || in_byte == ChLowF) begin
            nw = 3'd0;
          end else if (in_byte == ChLowU) begin
            phase_next = PhHex;
            hex_n_next = 2'd0;
          end else begin
            w[0] = in_byte;
            nw   = 3'd1;
          end
        end
        PhHex: begin
          if (!hd[4]) begin
            // Bad digit: replay the gathered characters, then treat the
            // byte as ordinary text.
            phase_next = PhNormal;
            hex_n_next = 2'd0;
            for (int i = 0; i < 3; i++) begin
              if (2'(i) < e_n) begin
                w[i] = e_ch[i];
              end
            end
            nw = {1'b0, e_n};
            if (in_byte == ChNul || in_byte == ChQuote) begin
              fin = 1'b1;
            end else if (in_byte == ChBslash) begin
              phase_next = PhEscape;
            end else begin
              w[e_n] = in_byte;
              nw     = {1'b0, e_n} + 3'd1;
            end
          end else if (e_n != 2'd3) begin
            hex_ch_next[e_n] = in_byte;
            hex_n_next       = e_n + 2'd1;
          end else begin
            phase_next = PhNormal;
            hex_n_next = 2'd0;
            if (cp >= CpSurLo && cp <= CpSurHi) begin
              nw = 3'd0;
            end else if (cp < CpTwoMin) begin
              w[0] = cp[7:0];
              nw   = 3'd1;
            end else if (cp < CpThrMin) begin
              // The whole sequence is dropped when it does not fit.
              if (r_sat >= 3'd2) begin
                w[0] = LeadTwo | {3'b000, cp[10:6]};
                w[1] = ContMark | {2'b00, cp[5:0]};
                nw   = 3'd2;
              end
            end else if (r_sat >= 3'd3) begin
              w[0] = LeadThr | {4'h0, cp[15:12]};
              w[1] = ContMark | {2'b00, cp[11:6]};
              w[2] = ContMark | {2'b00, cp[5:0]};
              nw   = 3'd3;
            end
          end
        end
        default: begin
          phase_next = PhNormal;
          if (in_byte == ChNul || in_byte == ChQuote) begin
            fin = 1'b1;
          end else if (in_byte == ChBslash) begin
            phase_next = PhEscape;
          end else begin
            w[0] = in_byte;
            nw   = 3'd1;
          end
        end
      endcase
    end

    // Writes stop once the buffer fills; an end marker follows only if the
    // string is still open after the writes.
    if (e_ended || full) begin
      e_cnt = 3'd0;
    end else begin
      e_cnt = (nw < r_sat) ? nw : r_sat;
    end
    fin_out = !e_ended && (full || (fin && (nw < r_sat)));

    for (int i = 0; i < MaxRes; i++) begin
      res[i] = '0;
      if (3'(i) < e_cnt) begin
        res[i].out_byte      = w[i];
        res[i].byte_valid    = 1'b1;
        res[i].string_done   = (3'(i) + 3'd1) == r_sat;
        res[i].written_count = 10'(e_bw + CntW'(i) + CntW'(1));
      end else if (3'(i) == e_cnt && fin_out) begin
        res[i].string_done   = 1'b1;
        res[i].written_count = 10'(e_bw + CntW'(e_cnt));
      end
    end

    res_cnt = item_valid ? (e_cnt + {2'b00, fin_out}) : 3'd0;

    bw_next    = e_bw + CntW'(e_cnt);
    ended_next = e_ended || fin_out || ((nw != 3'd0) && (nw >= r_sat) && !full);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PhNormal;
      hex_n <= 2'd0;
      for (int i = 0; i < 3; i++) begin
        hex_ch[i] <= 8'h00;
      end
      bw    <= '0;
      ended <= 1'b1;
    end else if (item_valid) begin
      phase <= phase_next;
      hex_n <= hex_n_next;
      for (int i = 0; i < 3; i++) begin
        hex_ch[i] <= hex_ch_next[i];
      end
      bw    <= bw_next;
      ended <= ended_next;
    end
  end

  `JSU_ASSERT_NOW(a_idle_silent, clk, rst, item_valid && ended && !in_start, res_cnt == 3'd0, "idle decoder produced results")
  `JSU_ASSERT_NOW(a_full_one, clk, rst, item_valid && !e_ended && full, res_cnt == 3'd1, "full buffer must give exactly one end result")
  `JSU_ASSERT_NEXT(a_count_mono, clk, rst, item_valid && !in_start, bw >= $past(bw), "written count went backwards within a string")

endmodule

`default_nettype wire

// ----- rtl/jsu_result_fifo.sv -----
`default_nettype none

`include "json_string_unescape_utf8_core_macros.svh"

module jsu_result_fifo
  import jsu_pkg::*;
(
  input  wire logic                     clk,
  input  wire logic                     rst,
  input  wire logic [2:0]               wr_cnt,
  input  wire jsu_res_t [MaxRes-1:0]    wr_data,
  output logic [ResQCw-1:0]             free,
  output logic                          head_valid,
  input  wire logic                     head_ready,
  output jsu_res_t                      head
);

  jsu_res_t            mem [ResQDepth];
  logic [ResQAw-1:0]   wr_ptr;
  logic [ResQAw-1:0]   rd_ptr;
  logic [ResQCw-1:0]   count;
  logic                pop;

  assign head_valid = count != '0;
  assign head       = mem[rd_ptr];
  assign pop        = head_valid && head_ready;
  assign free       = ResQCw'(ResQDepth) - count;

  always_ff @(posedge clk) begin
    for (int i = 0; i < MaxRes; i++) begin
      if (3'(i) < wr_cnt) begin
        mem[wr_ptr + ResQAw'(i)] <= wr_data[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr + ResQAw'(wr_cnt);
      rd_ptr <= rd_ptr + ResQAw'(pop);
      count  <= count + ResQCw'(wr_cnt) - ResQCw'(pop);
    end
  end

  `JSU_ASSERT_NOW(a_no_overflow, clk, rst, wr_cnt != 3'd0, ResQCw'(wr_cnt) <= free, "result queue overflow")
  `JSU_ASSERT_NOW(a_count_range, clk, rst, 1'b1, count <= ResQCw'(ResQDepth), "result queue count out of range")
  `JSU_ASSERT_NEXT(a_push_shows, clk, rst, count == '0 && wr_cnt != 3'd0, head_valid, "pushed result not presented")

endmodule

`default_nettype wire

// ----- rtl/json_string_unescape_utf8_core.sv -----
// An input item's first result is offered on the output after the input register and the result queue.
// Throughput: one input item per cycle while items yield at most one result each and m_tready
//   stays high; the output port sends one result per cycle, so an item's results leave one by one.
// The eight-entry result queue must have four free entries before the decode stage advances.
// Reset (rst, synchronous): queue emptied, decoder idle until an item with string_start,
//   out_capacity set to 64, or to MAX_CAPACITY when that is smaller.
`default_nettype none

module json_string_unescape_utf8_core
  import jsu_pkg::*;
#(
  parameter int MAX_CAPACITY = 1024
) (
  input  wire logic             clk,
  input  wire logic             rst,
  // Input stream.
  input  wire logic             s_tvalid,
  output logic                  s_tready,
  input  wire logic [7:0]       s_tdata,   // [7:0] in_byte
  input  wire logic             s_tuser,   // [0] string_start
  // Result stream.
  output logic                  m_tvalid,
  input  wire logic             m_tready,
  output logic [23:0]           m_tdata,   // [7:0] out_byte, [17:8] written_count, rest zero
  output logic                  m_tuser,   // [0] byte_valid
  output logic                  m_tlast,   // string_done
  // Configuration: out_capacity.
  input  wire logic             cfg_valid,
  output logic                  cfg_ready,
  input  wire logic [CapW-1:0]  cfg_data
);

  // Capacities above MAX_CAPACITY behave as MAX_CAPACITY. The clamp is applied
  // when the register is written, so the decoder sees the effective value.
  localparam logic [CapW-1:0] CapMax =
    (MAX_CAPACITY >= (1 << CapW) - 1) ? {CapW{1'b1}} : CapW'(MAX_CAPACITY);
  localparam logic [CapW-1:0] CapReset = (CapW'(64) > CapMax) ? CapMax : CapW'(64);

  logic [CapW-1:0]       cap;

  // Input register: holds one accepted item until the decoder can retire it.
  logic                  stage_valid;
  logic [7:0]            stage_byte;
  logic                  stage_start;
  logic                  advance;

  logic [2:0]            res_cnt;
  jsu_res_t [MaxRes-1:0] res;
  logic [ResQCw-1:0]     q_free;
  jsu_res_t              head;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cap <= CapReset;
    end else if (cfg_valid) begin
      cap <= (cfg_data > CapMax) ? CapMax : cfg_data;
    end
  end

  // The decoder retires the held item only when the queue can take the
  // largest burst one item can produce. The input side never looks at
  // m_tready, so a stalled consumer only blocks once fewer than four queue entries are free.
  assign advance  = stage_valid && (q_free >= ResQCw'(MaxRes));
  assign s_tready = !stage_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
    end else if (s_tvalid && s_tready) begin
      stage_valid <= 1'b1;
    end else if (advance) begin
      stage_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      stage_byte  <= s_tdata;
      stage_start <= s_tuser;
    end
  end

  jsu_decode u_decode (
    .clk        (clk),
    .rst        (rst),
    .item_valid (advance),
    .in_byte    (stage_byte),
    .in_start   (stage_start),
    .cap        (cap),
    .res_cnt    (res_cnt),
    .res        (res)
  );

  jsu_result_fifo u_result_fifo (
    .clk        (clk),
    .rst        (rst),
    .wr_cnt     (res_cnt),
    .wr_data    (res),
    .free       (q_free),
    .head_valid (m_tvalid),
    .head_ready (m_tready),
    .head       (head)
  );

  assign m_tdata = {6'b000000, head.written_count, head.out_byte};
  assign m_tuser = head.byte_valid;
  assign m_tlast = head.string_done;

endmodule

`default_nettype wire

// ----- tb/json_string_unescape_utf8_core_tb.sv -----
`timescale 1ns / 100ps

module json_string_unescape_utf8_core_tb;
  import jsu_pkg::*;

  // The decoder under test is built with its usual capacity ceiling.
  localparam int MaxCap = 1024;

  // Idle cycles allowed before the run is declared hung. The slowest correct
  // stretch is a sender gap, the input register and result queue, and a
  // receiver stall on each of up to four results; this is many times that.
  localparam int WatchdogLimit = 2000;

  // Cycles to let pass after the last expected result before touching the
  // capacity register. This covers items that make no result but may still
  // sit in the two-stage pipeline.
  localparam int SettleCycles = 12;

  // Raw characters the decoder reacts to.
  localparam logic [7:0] CH_NUL     = 8'h00;
  localparam logic [7:0] CH_QUOTE   = 8'h22;
  localparam logic [7:0] CH_SLASH   = 8'h2F;
  localparam logic [7:0] CH_BSLASH  = 8'h5C;
  localparam logic [7:0] CH_LOW_N   = 8'h6E;
  localparam logic [7:0] CH_LOW_T   = 8'h74;
  localparam logic [7:0] CH_LOW_R   = 8'h72;
  localparam logic [7:0] CH_LOW_B   = 8'h62;
  localparam logic [7:0] CH_LOW_F   = 8'h66;
  localparam logic [7:0] CH_LOW_U   = 8'h75;
  localparam logic [7:0] CH_DIGIT0  = 8'h30;
  localparam logic [7:0] CH_DIGIT9  = 8'h39;
  localparam logic [7:0] CH_UPPER_A = 8'h41;
  localparam logic [7:0] CH_UPPER_F = 8'h46;
  localparam logic [7:0] CH_LOWER_A = 8'h61;
  localparam logic [7:0] CH_LOWER_F = 8'h66;

  // Decoded control bytes.
  localparam logic [7:0] BYTE_LF  = 8'h0A;
  localparam logic [7:0] BYTE_TAB = 8'h09;

  // Code point ranges and UTF-8 framing.
  localparam logic [15:0] SURR_FIRST   = 16'hD800;
  localparam logic [15:0] SURR_LAST    = 16'hDFFF;
  localparam logic [15:0] ONE_BYTE_END = 16'h0080;
  localparam logic [15:0] TWO_BYTE_END = 16'h0800;
  localparam logic [7:0]  LEAD_2       = 8'hC0;
  localparam logic [7:0]  LEAD_3       = 8'hE0;
  localparam logic [7:0]  CONT         = 8'h80;

  typedef enum logic [1:0] {
    DEC_NORMAL = 2'd0,
    DEC_ESCAPE = 2'd1,
    DEC_HEX    = 2'd2
  } dec_phase_t;

  // One raw byte of a string body and its start-of-string flag.
  typedef struct packed {
    logic [7:0] in_byte;
    logic       first;
  } feed_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic              s_tvalid = 1'b0;
  logic              s_tready;
  logic [7:0]        s_tdata  = '0;  // [7:0] in_byte
  logic              s_tuser  = 1'b0; // [0] string_start
  logic              m_tvalid;
  logic              m_tready = 1'b0;
  logic [23:0]       m_tdata;        // [7:0] out_byte, [17:8] written_count, rest zero
  logic              m_tuser;        // [0] byte_valid
  logic              m_tlast;
  logic              cfg_valid = 1'b0;
  logic              cfg_ready;
  logic [CapW-1:0]   cfg_data  = '0;

  json_string_unescape_utf8_core #(
    .MAX_CAPACITY(MaxCap)
  ) DUT (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_data (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Bytes waiting to be sent and decoded bytes waiting to be seen.
  feed_t    feed_q[$];
  jsu_res_t expected_q[$];
  bit       start_pending;
  bit       calm;
  int       err_count;

  // Our own copy of the decoder state. The capacity starts at its reset value.
  logic [10:0] capacity_reg = 11'd64;
  dec_phase_t  dec_phase    = DEC_NORMAL;
  logic [1:0]  hex_count    = 2'd0;
  logic [7:0]  hex_buf [0:2] = '{8'h00, 8'h00, 8'h00};
  int unsigned out_count    = 0;
  bit          str_ended    = 1'b1;

  // ---------------------------------------------------------------------------
  // Decoder prediction
  // ---------------------------------------------------------------------------

  // Capacities above the ceiling behave as the ceiling.
  function automatic int unsigned cap_limit();
    return (int'(capacity_reg) > MaxCap) ? MaxCap : int'(capacity_reg);
  endfunction

  // Full means there is only room left for the terminator.
  function automatic bit buffer_full();
    return out_count + 1 >= cap_limit();
  endfunction

  function automatic int hex_value(logic [7:0] c);
    if (c >= CH_DIGIT0 && c <= CH_DIGIT9) return int'(c) - int'(CH_DIGIT0);
    if (c >= CH_LOWER_A && c <= CH_LOWER_F) return int'(c) - int'(CH_LOWER_A) + 10;
    if (c >= CH_UPPER_A && c <= CH_UPPER_F) return int'(c) - int'(CH_UPPER_A) + 10;
    return -1;
  endfunction

  function automatic void push_decoded(logic [7:0] b, bit valid, bit done);
    jsu_res_t r;
    r.out_byte      = valid ? b : 8'h00;
    r.byte_valid    = valid;
    r.string_done   = done;
    r.written_count = out_count[9:0];
    expected_q.push_back(r);
  endfunction

  // End marker: no byte, only the done flag.
  function automatic void end_string();
    str_ended = 1'b1;
    push_decoded(8'h00, 1'b0, 1'b1);
  endfunction

  // A written byte that fills the buffer also closes the string, and any
  // bytes still pending from the same item are then dropped.
  function automatic void write_out(logic [7:0] b);
    bit done;
    if (str_ended) return;
    out_count++;
    done = buffer_full();
    if (done) str_ended = 1'b1;
    push_decoded(b, 1'b1, done);
  endfunction

  function automatic void take_plain(logic [7:0] b);
    if (str_ended) return;
    if (b == CH_NUL || b == CH_QUOTE) end_string();
    else if (b == CH_BSLASH) dec_phase = DEC_ESCAPE;
    else write_out(b);
  endfunction

  // A multi-byte sequence is written whole or not at all; surrogates vanish.
  function automatic void emit_code(logic [15:0] cp);
    if (cp >= SURR_FIRST && cp <= SURR_LAST) return;
    if (cp < ONE_BYTE_END) begin
      write_out(cp[7:0]);
    end else if (cp < TWO_BYTE_END) begin
      if (out_count + 2 < cap_limit()) begin
        write_out(LEAD_2 | {3'b000, cp[10:6]});
        write_out(CONT | {2'b00, cp[5:0]});
      end
    end else if (out_count + 3 < cap_limit()) begin
      write_out(LEAD_3 | {4'b0000, cp[15:12]});
      write_out(CONT | {2'b00, cp[11:6]});
      write_out(CONT | {2'b00, cp[5:0]});
    end
  endfunction

  // Works out every decoded result that one accepted raw byte causes.
  function automatic void predict_item(logic [7:0] b, logic first);
    int          d;
    int          n;
    logic [15:0] cp;
    if (first) begin
      dec_phase = DEC_NORMAL;
      hex_count = 2'd0;
      hex_buf   = '{8'h00, 8'h00, 8'h00};
      out_count = 0;
      str_ended = 1'b0;
    end
    if (str_ended) return;
    if (buffer_full()) begin
      end_string();
      return;
    end
    case (dec_phase)
      DEC_ESCAPE: begin
        dec_phase = DEC_NORMAL;
        if (b == CH_NUL) begin
          end_string();
        end else if (b == CH_LOW_N) begin
          write_out(BYTE_LF);
        end else if (b == CH_LOW_T) begin
          write_out(BYTE_TAB);
        end else if (b == CH_LOW_R || b == CH_LOW_B || b == CH_LOW_F) begin
          // These escapes are swallowed.
        end else if (b == CH_LOW_U) begin
          dec_phase = DEC_HEX;
          hex_count = 2'd0;
        end else begin
          write_out(b);
        end
      end
      DEC_HEX: begin
        d = hex_value(b);
        if (d < 0) begin
          // Replay the digits gathered so far, then treat this byte as plain.
          n         = int'(hex_count);
          dec_phase = DEC_NORMAL;
          hex_count = 2'd0;
          for (int i = 0; i < n; i++) write_out(hex_buf[i]);
          take_plain(b);
        end else if (hex_count < 2'd3) begin
          hex_buf[hex_count] = b;
          hex_count++;
        end else begin
          cp = {4'(hex_value(hex_buf[0])), 4'(hex_value(hex_buf[1])),
                4'(hex_value(hex_buf[2])), d[3:0]};
          dec_phase = DEC_NORMAL;
          hex_count = 2'd0;
          emit_code(cp);
        end
      end
      default: begin
        dec_phase = DEC_NORMAL;
        take_plain(b);
      end
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------

  function automatic void add_item(logic [7:0] b);
    feed_q.push_back('{in_byte: b, first: start_pending});
    start_pending = 1'b0;
  endfunction

  // The next byte queued opens a new string.
  function automatic void begin_string();
    start_pending = 1'b1;
  endfunction

  function automatic void add_text(string s);
    for (int i = 0; i < s.len(); i++) add_item(s[i]);
  endfunction

  function automatic logic [7:0] hex_char(logic [3:0] v, bit upper);
    if (v < 4'd10) return CH_DIGIT0 + {4'h0, v};
    return (upper ? CH_UPPER_A : CH_LOWER_A) + {4'h0, v} - 8'd10;
  endfunction

  function automatic logic [7:0] non_hex_byte();
    logic [7:0] c;
    do c = 8'($urandom_range(0, 255)); while (hex_value(c) >= 0);
    return c;
  endfunction

  // Queues one string body. Most of it is well formed: plain text, simple
  // escapes and complete \u escapes spread over all UTF-8 lengths and the
  // surrogate range. The rest is raw noise and \u escapes cut short.
  function automatic void queue_random_string();
    int          tokens;
    int          kind;
    int          ndig;
    logic [15:0] cp;
    logic [7:0]  c;
    begin_string();
    tokens = ($urandom_range(0, 7) == 0) ? $urandom_range(10, 30) : $urandom_range(0, 8);
    for (int t = 0; t < tokens; t++) begin
      kind = $urandom_range(0, 99);
      if (kind < 45) begin
        do c = 8'($urandom_range(1, 255)); while (c == CH_QUOTE || c == CH_BSLASH);
        add_item(c);
      end else if (kind < 52) begin
        add_item(8'($urandom_range(0, 255)));
      end else if (kind < 72) begin
        add_item(CH_BSLASH);
        case ($urandom_range(0, 8))
          0: add_item(CH_LOW_N);
          1: add_item(CH_LOW_T);
          2: add_item(CH_LOW_R);
          3: add_item(CH_LOW_B);
          4: add_item(CH_LOW_F);
          5: add_item(CH_QUOTE);
          6: add_item(CH_BSLASH);
          7: add_item(CH_SLASH);
          default: add_item(8'($urandom_range(0, 255)));
        endcase
      end else if (kind < 90) begin
        case ($urandom_range(0, 3))
          0: cp = 16'($urandom_range(0, 16'h007F));
          1: cp = 16'($urandom_range(16'h0080, 16'h07FF));
          2: cp = 16'($urandom_range(SURR_FIRST, SURR_LAST));
          default: cp = 16'($urandom_range(16'h0800, 16'hFFFF));
        endcase
        add_item(CH_BSLASH);
        add_item(CH_LOW_U);
        for (int i = 3; i >= 0; i--) begin
          add_item(hex_char(cp[4*i +: 4], 1'($urandom_range(0, 1))));
        end
      end else begin
        // Broken \u: a few good digits, then something that is not hex.
        ndig = $urandom_range(0, 3);
        add_item(CH_BSLASH);
        add_item(CH_LOW_U);
        for (int i = 0; i < ndig; i++) begin
          add_item(hex_char(4'($urandom_range(0, 15)), 1'($urandom_range(0, 1))));
        end
        case ($urandom_range(0, 3))
          0: add_item(CH_QUOTE);
          1: add_item(CH_NUL);
          2: add_item(CH_BSLASH);
          default: add_item(non_hex_byte());
        endcase
      end
    end
    case ($urandom_range(0, 19)) inside
      [0:11]:  add_item(CH_QUOTE);
      [12:14]: add_item(CH_NUL);
      [15:16]: begin
        add_item(CH_BSLASH);
        add_item(CH_NUL);
      end
      default: begin
        // Left open: the next string start or the buffer limit closes it.
      end
    endcase
  endfunction

  // Waits until every byte is sent and every decoded byte has come back,
  // then lets the pipeline drain bytes that decode to nothing.
  task automatic wait_idle();
    while (feed_q.size() != 0 || expected_q.size() != 0) @(negedge clk);
    repeat (SettleCycles) @(negedge clk);
  endtask

  // Writes out_capacity; only called while the decoder is idle.
  task automatic set_capacity(input logic [10:0] cap);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= cap;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid    <= 1'b0;
    capacity_reg = cap;
    @(negedge clk);
  endtask

  task automatic random_phase(input logic [10:0] cap, input int budget);
    int fed;
    int depth0;
    fed = 0;
    set_capacity(cap);
    while (fed < budget) begin
      depth0 = feed_q.size();
      queue_random_string();
      fed += feed_q.size() - depth0;
      // Stray bytes after a string; mostly ignored since the string ended.
      if ($urandom_range(0, 4) == 0) begin
        repeat ($urandom_range(1, 2)) add_item(8'($urandom_range(0, 255)));
      end
    end
    wait_idle();
  endtask

  // ---------------------------------------------------------------------------
  // Input driver: one raw byte per item, held until taken, with random gaps.
  // ---------------------------------------------------------------------------
  int gap_left = 0;

  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
      s_tdata  <= '0;
      s_tuser  <= 1'b0;
    end else if (!s_tvalid || s_tready) begin
      if (s_tvalid) begin
        predict_item(s_tdata, s_tuser);
        void'(feed_q.pop_front());
      end
      if (gap_left != 0) begin
        gap_left--;
        s_tvalid <= 1'b0;
      end else if (feed_q.size() == 0) begin
        s_tvalid <= 1'b0;
      end else if (!calm && $urandom_range(0, 11) == 0) begin
        // Start a random gap; this cycle is part of it.
        gap_left = $urandom_range(0, 11);
        s_tvalid <= 1'b0;
      end else begin
        s_tvalid <= 1'b1;
        s_tdata  <= feed_q[0].in_byte;
        s_tuser  <= feed_q[0].first;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Result monitor: stalls at random and checks each decoded item in order.
  // ---------------------------------------------------------------------------
  int stall_left = 0;

  function automatic void check_result(jsu_res_t got);
    jsu_res_t want;
    if (expected_q.size() == 0) begin
      $error("unexpected result: out_byte %02h byte_valid %0d string_done %0d written_count %0d",
             got.out_byte, got.byte_valid, got.string_done, got.written_count);
      err_count++;
      return;
    end
    want = expected_q.pop_front();
    if (got.out_byte !== want.out_byte) begin
      $error("out_byte: expected %02h, got %02h", want.out_byte, got.out_byte);
      err_count++;
    end
    if (got.byte_valid !== want.byte_valid) begin
      $error("byte_valid: expected %0d, got %0d", want.byte_valid, got.byte_valid);
      err_count++;
    end
    if (got.string_done !== want.string_done) begin
      $error("string_done: expected %0d, got %0d", want.string_done, got.string_done);
      err_count++;
    end
    if (got.written_count !== want.written_count) begin
      $error("written_count: expected %0d, got %0d", want.written_count, got.written_count);
      err_count++;
    end
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) begin
        check_result('{out_byte: m_tdata[7:0], byte_valid: m_tuser, string_done: m_tlast,
                       written_count: m_tdata[17:8]});
      end
      if (stall_left != 0) begin
        stall_left--;
        m_tready <= 1'b0;
      end else if (!calm && $urandom_range(0, 15) == 0) begin
        stall_left = $urandom_range(0, 11);
        m_tready <= 1'b0;
      end else begin
        m_tready <= 1'b1;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Watchdog: any handshake on any channel counts as progress.
  // ---------------------------------------------------------------------------
  int quiet = 0;

  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready)) begin
      quiet <= 0;
    end else if (quiet >= WatchdogLimit) begin
      $display("json_string_unescape_utf8_core_tb: errors");
      $finish;
    end else begin
      quiet <= quiet + 1;
    end
  end

  // ---------------------------------------------------------------------------
  // Test sequence
  // ---------------------------------------------------------------------------
  initial begin
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Reset capacity of 64: newline escape, \u0000 as a real zero byte, a \u
    // cut short by a bad digit so its two digits are replayed, then a quote.
    begin_string();
    add_text("x\\n\\u0000\\u7Fg\"");
    wait_idle();

    // Capacity 3: a surrogate is dropped, a three-byte sequence has no room,
    // the tab fills the buffer, and the trailing byte is ignored.
    set_capacity(11'd3);
    begin_string();
    add_text("a\\uD9ff\\uFFFF\\tc");
    wait_idle();

    // Random strings across a range of capacities, the extremes included.
    random_phase(11'd1024, 8);
    random_phase(11'd0, 4);
    random_phase(11'd6, 8);
    random_phase(11'd2047, 8);
    random_phase(11'd1, 4);
    random_phase(11'd12, 8);
    random_phase(11'd2, 4);
    random_phase(11'd40, 8);

    // Leave a string open, shrink the buffer under it, then continue it: the
    // next byte finds the buffer already full.
    set_capacity(11'd1024);
    begin_string();
    add_text("abc");
    wait_idle();
    set_capacity(11'd2);
    add_text("d");
    begin_string();
    add_text("ef");
    wait_idle();

    // Last stretch with both sides running flat out.
    calm = 1'b1;
    random_phase(11'd20, 8);

    if (err_count == 0) begin
      $display("json_string_unescape_utf8_core_tb: clean");
    end else begin
      $display("json_string_unescape_utf8_core_tb: errors");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
+incdir+rtl
rtl/jsu_pkg.sv
rtl/jsu_decode.sv
rtl/jsu_result_fifo.sv
rtl/json_string_unescape_utf8_core.sv
tb/json_string_unescape_utf8_core_tb.sv
